// ===== rtl/core/umts_pkg.sv =====
// Shared types, codes and helpers for the USB mode transition sequencer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package umts_pkg;

  // Command codes carried by an input item
  localparam logic [1:0] CMD_STEP    = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_RECOVER = 2'd2;

  // Mode codes
  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_AUX      = 3'd1;
  localparam logic [2:0] MODE_AUX_REC  = 3'd2;
  localparam logic [2:0] MODE_STATUS   = 3'd3;
  localparam logic [2:0] MODE_USB      = 3'd4;
  localparam logic [2:0] MODE_PROTOCOL = 3'd5;

  // Transfer status codes (the reserved code behaves as pending)
  localparam logic [1:0] XS_COMPLETE = 2'd1;
  localparam logic [1:0] XS_FAILED   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STANDARD_SETTLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USB_SETTLE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_WAIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_START_DL = 3'd4;

  // Configuration reset values in milliseconds
  localparam logic [15:0] RST_START_DELAY       = 16'd10;
  localparam logic [15:0] RST_STANDARD_SETTLE   = 16'd100;
  localparam logic [15:0] RST_USB_SETTLE        = 16'd300;
  localparam logic [15:0] RST_PROTOCOL_WAIT     = 16'd1000;
  localparam logic [15:0] RST_PROTOCOL_START_DL = 16'd500;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_WAIT_AUX    = 4'd1,
    PH_WAIT_USB    = 4'd2,
    PH_WAIT_STATUS = 4'd3,
    PH_WAIT_INIT   = 4'd4,
    PH_WAIT_PROTO  = 4'd5,
    PH_WAIT_START  = 4'd6,
    PH_WAIT_XFER   = 4'd7,
    PH_WAIT_SETTLE = 4'd8,
    PH_ACTIVE      = 4'd9
  } phase_t;

  // One input item
  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  requested_mode;
    logic [31:0] now_ms;
    logic        aux_handshake_done;
    logic        usb_ready;
    logic        wheel_status_seen;
    logic [1:0]  xfer_status;
    logic        protocol_acked;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic act_prepare_usb;
    logic act_enable_timer;
    logic act_disable_timer;
    logic act_start_transfer;
    logic act_request_aux;
    logic act_mark_status;
    logic act_init_direct;
    logic act_request_protocol;
    logic act_activate_updater;
    logic act_service_updater;
    logic act_restore_normal;
    logic is_active;
  } out_item_t;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] start_wait_ms;
    logic [15:0] standard_settle_ms;
    logic [15:0] usb_settle_ms;
    logic [15:0] protocol_wait_ms;
    logic [15:0] proto_start_wait_ms;
  } cfg_t;

  // Sequencer state carried between the top level and the step logic
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  mode;
    logic        recovery;
    logic [31:0] start_deadline;
    logic [31:0] settle_deadline;
  } seq_state_t;

  // A deadline has passed when now minus deadline is strictly positive as a signed value.
  function automatic logic passed(input logic [31:0] now, input logic [31:0] deadline);
    logic [31:0] diff;
    diff = now - deadline;
    return (diff != 32'd0) && !diff[31];
  endfunction

  // Deadline is the time plus a 16-bit delay, wrapping modulo 2^32.
  function automatic logic [31:0] add_delay(input logic [31:0] now, input logic [15:0] delay);
    logic [31:0] ext;
    ext = {16'd0, delay};
    return now + ext;
  endfunction

endpackage

// ===== rtl/core/umts_step.sv =====
// Combinational step logic: next sequencer state and the action flags for one item.
// Depends on umts_pkg for the item, state and configuration types.
module umts_step (
  input  umts_pkg::in_item_t   item,
  input  umts_pkg::seq_state_t st,
  input  umts_pkg::cfg_t       cfg,
  output umts_pkg::seq_state_t st_nxt,
  output umts_pkg::out_item_t  result
);

  logic [1:0]  xs;
  logic [31:0] now;

  assign xs  = item.xfer_status;
  assign now = item.now_ms;

  // Next state: phase, mode, recovery flag and deadlines.
  always_comb begin
    st_nxt = st;
    unique case (item.command)
      umts_pkg::CMD_STEP: begin
        unique case (st.phase)
          umts_pkg::PH_WAIT_AUX: begin
            if (item.aux_handshake_done) begin
              st_nxt.start_deadline  = umts_pkg::add_delay(now, cfg.start_wait_ms);
              st_nxt.settle_deadline = umts_pkg::add_delay(now, cfg.standard_settle_ms);
              st_nxt.phase           = umts_pkg::PH_WAIT_START;
            end
          end
          umts_pkg::PH_WAIT_USB: begin
            if (item.usb_ready) begin
              st_nxt.start_deadline  = umts_pkg::add_delay(now, cfg.start_wait_ms);
              st_nxt.settle_deadline = umts_pkg::add_delay(now, cfg.usb_settle_ms);
              st_nxt.phase           = umts_pkg::PH_WAIT_START;
            end
          end
          umts_pkg::PH_WAIT_STATUS: begin
            if (item.wheel_status_seen) begin
              st_nxt.start_deadline  = umts_pkg::add_delay(now, cfg.start_wait_ms);
              st_nxt.settle_deadline = umts_pkg::add_delay(now, cfg.standard_settle_ms);
              st_nxt.phase           = umts_pkg::PH_WAIT_START;
            end
          end
          umts_pkg::PH_WAIT_INIT: begin
            if (xs == umts_pkg::XS_COMPLETE) begin
              st_nxt.settle_deadline = umts_pkg::add_delay(now, cfg.standard_settle_ms);
              st_nxt.phase           = umts_pkg::PH_WAIT_SETTLE;
            end else if (xs == umts_pkg::XS_FAILED) begin
              st_nxt.settle_deadline = umts_pkg::add_delay(now, cfg.protocol_wait_ms);
              st_nxt.phase           = umts_pkg::PH_WAIT_PROTO;
            end
          end
          umts_pkg::PH_WAIT_PROTO: begin
            if (item.protocol_acked || umts_pkg::passed(now, st.settle_deadline)) begin
              st_nxt.start_deadline  = umts_pkg::add_delay(now, cfg.proto_start_wait_ms);
              st_nxt.settle_deadline = umts_pkg::add_delay(now, cfg.standard_settle_ms);
              st_nxt.phase           = umts_pkg::PH_WAIT_START;
            end
          end
          umts_pkg::PH_WAIT_START: begin
            if (umts_pkg::passed(now, st.start_deadline)) begin
              st_nxt.phase = umts_pkg::PH_WAIT_XFER;
            end
          end
          umts_pkg::PH_WAIT_XFER: begin
            priority if (xs == umts_pkg::XS_COMPLETE) begin
              st_nxt.phase = umts_pkg::PH_WAIT_SETTLE;
            end else if (xs == umts_pkg::XS_FAILED && st.recovery) begin
              st_nxt.mode     = umts_pkg::MODE_NORMAL;
              st_nxt.phase    = umts_pkg::PH_IDLE;
              st_nxt.recovery = 1'b0;
            end else if (st.mode == umts_pkg::MODE_USB &&
                         umts_pkg::passed(now, st.settle_deadline)) begin
              st_nxt.phase = umts_pkg::PH_WAIT_USB;
            end else begin
              st_nxt.phase = st.phase;
            end
          end
          umts_pkg::PH_WAIT_SETTLE: begin
            if (umts_pkg::passed(now, st.settle_deadline)) begin
              st_nxt.phase = umts_pkg::PH_ACTIVE;
            end
          end
          default: begin
            st_nxt = st;
          end
        endcase
      end
      umts_pkg::CMD_START: begin
        if (st.phase == umts_pkg::PH_IDLE) begin
          st_nxt.mode     = item.requested_mode;
          st_nxt.recovery = 1'b0;
          unique case (item.requested_mode)
            umts_pkg::MODE_AUX, umts_pkg::MODE_AUX_REC: st_nxt.phase = umts_pkg::PH_WAIT_AUX;
            umts_pkg::MODE_STATUS:   st_nxt.phase = umts_pkg::PH_WAIT_STATUS;
            umts_pkg::MODE_USB:      st_nxt.phase = umts_pkg::PH_WAIT_USB;
            umts_pkg::MODE_PROTOCOL: st_nxt.phase = umts_pkg::PH_WAIT_INIT;
            default:                 st_nxt.mode  = umts_pkg::MODE_NORMAL;
          endcase
        end
      end
      umts_pkg::CMD_RECOVER: begin
        if (st.phase == umts_pkg::PH_IDLE) begin
          st_nxt.mode            = umts_pkg::MODE_AUX_REC;
          st_nxt.recovery        = 1'b1;
          st_nxt.start_deadline  = umts_pkg::add_delay(now, cfg.start_wait_ms);
          st_nxt.settle_deadline = umts_pkg::add_delay(now, cfg.standard_settle_ms);
          st_nxt.phase           = umts_pkg::PH_WAIT_START;
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

  // Action flags. Arming a start uses the mode in force after this item.
  always_comb begin
    result           = '0;
    result.is_active = (st_nxt.phase == umts_pkg::PH_ACTIVE);
    unique case (item.command)
      umts_pkg::CMD_STEP: begin
        unique case (st.phase)
          umts_pkg::PH_ACTIVE: result.act_service_updater = 1'b1;
          umts_pkg::PH_WAIT_AUX, umts_pkg::PH_WAIT_USB, umts_pkg::PH_WAIT_STATUS,
          umts_pkg::PH_WAIT_PROTO: begin
            // Any of these phases that moves on arms the start deadline
            if (st_nxt.phase == umts_pkg::PH_WAIT_START) begin
              result.act_prepare_usb  = 1'b1;
              result.act_enable_timer = (st_nxt.mode != umts_pkg::MODE_STATUS);
              result.act_init_direct  = (st.phase == umts_pkg::PH_WAIT_STATUS);
            end
          end
          umts_pkg::PH_WAIT_INIT: begin
            if (xs == umts_pkg::XS_COMPLETE) begin
              result.act_prepare_usb = 1'b1;
            end else if (xs == umts_pkg::XS_FAILED) begin
              result.act_disable_timer    = 1'b1;
              result.act_request_protocol = 1'b1;
            end
          end
          umts_pkg::PH_WAIT_START: begin
            if (st_nxt.phase == umts_pkg::PH_WAIT_XFER) begin
              result.act_start_transfer = 1'b1;
              result.act_enable_timer   = (st.mode == umts_pkg::MODE_STATUS);
            end
          end
          umts_pkg::PH_WAIT_XFER: begin
            if (st_nxt.phase == umts_pkg::PH_IDLE) begin
              result.act_disable_timer  = 1'b1;
              result.act_restore_normal = 1'b1;
            end
          end
          umts_pkg::PH_WAIT_SETTLE: begin
            result.act_activate_updater = (st_nxt.phase == umts_pkg::PH_ACTIVE);
          end
          default: begin
            result.act_service_updater = 1'b0;
          end
        endcase
      end
      umts_pkg::CMD_START: begin
        if (st.phase == umts_pkg::PH_IDLE) begin
          unique case (item.requested_mode)
            umts_pkg::MODE_AUX, umts_pkg::MODE_AUX_REC: result.act_request_aux = 1'b1;
            umts_pkg::MODE_STATUS: result.act_mark_status = 1'b1;
            umts_pkg::MODE_PROTOCOL: begin
              result.act_enable_timer   = 1'b1;
              result.act_start_transfer = 1'b1;
            end
            default: result.act_request_aux = 1'b0;
          endcase
        end
      end
      umts_pkg::CMD_RECOVER: begin
        if (st.phase == umts_pkg::PH_IDLE) begin
          result.act_prepare_usb  = 1'b1;
          result.act_enable_timer = 1'b1;
        end
      end
      default: begin
        result.act_prepare_usb = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/usb_mode_transition_sequencer.sv =====
// Top level of the USB mode transition sequencer: input register, state, result register.
// Depends on umts_pkg and instantiates umts_step.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_item  (umts_pkg::in_item_t)
//   out_     output     out_valid / out_stall  out_item (umts_pkg::out_item_t)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item is registered in the input register and is then resolved into the result register;
// one item is taken per cycle while the result side does not stall. The rate is set by the
// single state update per cycle (phase decode, a 32-bit add and a wraparound compare).
// Reset is synchronous and active low; it restores the register defaults and the idle phase.
// A stall on the result side holds the result register, then the input register, then in_stall.
module usb_mode_transition_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  umts_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output umts_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [umts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);

  umts_pkg::in_item_t   s1_r;
  logic                 s1_v_r;
  umts_pkg::seq_state_t st_r, st_nxt;
  umts_pkg::cfg_t       cfg_r;
  umts_pkg::out_item_t  out_r, result;
  logic                 out_v_r;
  logic                 adv;
  logic                 in_acc;

  // Handshake control
  assign adv       = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  umts_step u_step (
    .item   (s1_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .result (result)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_wait_ms       <= umts_pkg::RST_START_DELAY;
      cfg_r.standard_settle_ms  <= umts_pkg::RST_STANDARD_SETTLE;
      cfg_r.usb_settle_ms       <= umts_pkg::RST_USB_SETTLE;
      cfg_r.protocol_wait_ms    <= umts_pkg::RST_PROTOCOL_WAIT;
      cfg_r.proto_start_wait_ms <= umts_pkg::RST_PROTOCOL_START_DL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        umts_pkg::CFG_START_DELAY:       cfg_r.start_wait_ms       <= cfg_data;
        umts_pkg::CFG_STANDARD_SETTLE:   cfg_r.standard_settle_ms  <= cfg_data;
        umts_pkg::CFG_USB_SETTLE:        cfg_r.usb_settle_ms       <= cfg_data;
        umts_pkg::CFG_PROTOCOL_WAIT:     cfg_r.protocol_wait_ms    <= cfg_data;
        umts_pkg::CFG_PROTOCOL_START_DL: cfg_r.proto_start_wait_ms <= cfg_data;
        default:                         cfg_r <= cfg_r;
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_item;
    end
  end

  // Sequencer state advances once per resolved item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase           <= umts_pkg::PH_IDLE;
      st_r.mode            <= umts_pkg::MODE_NORMAL;
      st_r.recovery        <= 1'b0;
      st_r.start_deadline  <= 32'd0;
      st_r.settle_deadline <= 32'd0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= result;
    end
  end

endmodule

// ===== rtl/core/umts_checker.sv =====
// Port-level checks for the USB mode transition sequencer, bound to the top level.
// Depends on umts_pkg for the result item type.
module umts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input umts_pkg::out_item_t out_item
);

  // A result held by a stall keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // No result is offered straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Activating the updater always leaves the sequencer active.
  a_activate_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.act_activate_updater |-> out_item.is_active)
    else $error("activation without active phase");

  // Servicing only happens while active.
  a_service_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.act_service_updater |-> out_item.is_active)
    else $error("service outside active phase");

  // A failed recovery restores normal USB, stops the timer and is not in the active phase.
  a_restore: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.act_restore_normal |->
      out_item.act_disable_timer && !out_item.is_active)
    else $error("inconsistent restore result");

endmodule

bind usb_mode_transition_sequencer umts_checker u_umts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for usb_mode_transition_sequencer: directed items, recovery loops, one
// full walk into updater mode, random gaps and stalls. Depends on umts_pkg and the block's RTL.
module tb_top;

  // Codes that the package leaves unnamed
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam logic [1:0] XS_PENDING   = 2'd0;
  localparam logic [1:0] XS_RESERVED  = 2'd3;
  localparam logic [2:0] MODE_SPARE6  = 3'd6;
  localparam logic [2:0] MODE_SPARE7  = 3'd7;

  // Mirror of the sequencer state
  typedef struct packed {
    umts_pkg::phase_t ph;
    logic [2:0]       mode;
    logic             recov;
    logic [31:0]      start_dl;
    logic [31:0]      settle_dl;
  } seq_track_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  umts_pkg::in_item_t             in_item = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  umts_pkg::out_item_t            out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [umts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                    cfg_data = '0;

  // Bench state: the checking copy follows accepted items, the planning copy follows queued ones
  seq_track_t          track_st;
  seq_track_t          plan_st;
  umts_pkg::cfg_t      cfg_regs;
  logic [31:0]         plan_now;
  logic [2:0]          journey_mode;
  umts_pkg::in_item_t  pending_items[$];
  umts_pkg::out_item_t expected_actions[$];
  umts_pkg::in_item_t  next_item;
  umts_pkg::out_item_t predicted;
  umts_pkg::out_item_t oldest;
  logic                in_took = 1'b0;
  int                  gap_left = 0;
  int                  send_calm = 0;
  int                  stall_left = 0;
  int                  stall_calm = 0;
  int                  hold_left = 0;
  bit                  hold_done = 1'b0;
  int                  results_seen = 0;
  int                  fails = 0;

  usb_mode_transition_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A deadline counts as gone once the time is strictly ahead of it in wrapped signed terms.
  function automatic bit deadline_gone(input logic [31:0] now, input logic [31:0] dl);
    return $signed(now - dl) > 0;
  endfunction

  // Most idle stretches are short; a few are long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Set both deadlines and the prepare and timer flags, then wait for the transfer start.
  task automatic arm_transfer(inout seq_track_t s, input logic [31:0] now,
                              input logic [15:0] sd, input logic [15:0] st,
                              inout umts_pkg::out_item_t r);
    s.start_dl  = now + {16'd0, sd};
    s.settle_dl = now + {16'd0, st};
    s.ph        = umts_pkg::PH_WAIT_START;
    r.act_prepare_usb  = 1'b1;
    r.act_enable_timer = (s.mode != umts_pkg::MODE_STATUS);
  endtask

  // Expected actions for one item, updating the mirrored state.
  task automatic advance_sequencer(inout seq_track_t s, input umts_pkg::cfg_t c,
                                   input umts_pkg::in_item_t it,
                                   output umts_pkg::out_item_t r);
    r = '0;
    case (it.command)
      umts_pkg::CMD_STEP: begin
        case (s.ph)
          umts_pkg::PH_ACTIVE: r.act_service_updater = 1'b1;
          umts_pkg::PH_WAIT_AUX: begin
            if (it.aux_handshake_done)
              arm_transfer(s, it.now_ms, c.start_wait_ms, c.standard_settle_ms, r);
          end
          umts_pkg::PH_WAIT_USB: begin
            if (it.usb_ready)
              arm_transfer(s, it.now_ms, c.start_wait_ms, c.usb_settle_ms, r);
          end
          umts_pkg::PH_WAIT_STATUS: begin
            if (it.wheel_status_seen) begin
              arm_transfer(s, it.now_ms, c.start_wait_ms, c.standard_settle_ms, r);
              r.act_init_direct = 1'b1;
            end
          end
          umts_pkg::PH_WAIT_INIT: begin
            if (it.xfer_status == umts_pkg::XS_COMPLETE) begin
              s.settle_dl = it.now_ms + {16'd0, c.standard_settle_ms};
              s.ph = umts_pkg::PH_WAIT_SETTLE;
              r.act_prepare_usb = 1'b1;
            end else if (it.xfer_status == umts_pkg::XS_FAILED) begin
              s.settle_dl = it.now_ms + {16'd0, c.protocol_wait_ms};
              s.ph = umts_pkg::PH_WAIT_PROTO;
              r.act_disable_timer = 1'b1;
              r.act_request_protocol = 1'b1;
            end
          end
          umts_pkg::PH_WAIT_PROTO: begin
            // The acknowledgement or the timeout both lead on to the fallback start.
            if (it.protocol_acked || deadline_gone(it.now_ms, s.settle_dl))
              arm_transfer(s, it.now_ms, c.proto_start_wait_ms, c.standard_settle_ms, r);
          end
          umts_pkg::PH_WAIT_START: begin
            if (deadline_gone(it.now_ms, s.start_dl)) begin
              s.ph = umts_pkg::PH_WAIT_XFER;
              r.act_start_transfer = 1'b1;
              r.act_enable_timer = (s.mode == umts_pkg::MODE_STATUS);
            end
          end
          umts_pkg::PH_WAIT_XFER: begin
            if (it.xfer_status == umts_pkg::XS_COMPLETE) begin
              s.ph = umts_pkg::PH_WAIT_SETTLE;
            end else if (it.xfer_status == umts_pkg::XS_FAILED && s.recov) begin
              s.mode  = umts_pkg::MODE_NORMAL;
              s.ph    = umts_pkg::PH_IDLE;
              s.recov = 1'b0;
              r.act_disable_timer  = 1'b1;
              r.act_restore_normal = 1'b1;
            end else if (s.mode == umts_pkg::MODE_USB &&
                         deadline_gone(it.now_ms, s.settle_dl)) begin
              s.ph = umts_pkg::PH_WAIT_USB;
            end
          end
          umts_pkg::PH_WAIT_SETTLE: begin
            if (deadline_gone(it.now_ms, s.settle_dl)) begin
              s.ph = umts_pkg::PH_ACTIVE;
              r.act_activate_updater = 1'b1;
            end
          end
          default: ;
        endcase
      end
      umts_pkg::CMD_START: begin
        if (s.ph == umts_pkg::PH_IDLE) begin
          s.mode  = it.requested_mode;
          s.recov = 1'b0;
          case (it.requested_mode)
            umts_pkg::MODE_AUX, umts_pkg::MODE_AUX_REC: begin
              s.ph = umts_pkg::PH_WAIT_AUX;
              r.act_request_aux = 1'b1;
            end
            umts_pkg::MODE_STATUS: begin
              s.ph = umts_pkg::PH_WAIT_STATUS;
              r.act_mark_status = 1'b1;
            end
            umts_pkg::MODE_USB: s.ph = umts_pkg::PH_WAIT_USB;
            umts_pkg::MODE_PROTOCOL: begin
              s.ph = umts_pkg::PH_WAIT_INIT;
              r.act_enable_timer = 1'b1;
              r.act_start_transfer = 1'b1;
            end
            default: s.mode = umts_pkg::MODE_NORMAL;
          endcase
        end
      end
      umts_pkg::CMD_RECOVER: begin
        if (s.ph == umts_pkg::PH_IDLE) begin
          s.mode  = umts_pkg::MODE_AUX_REC;
          s.recov = 1'b1;
          arm_transfer(s, it.now_ms, c.start_wait_ms, c.standard_settle_ms, r);
        end
      end
      default: ;
    endcase
    r.is_active = (s.ph == umts_pkg::PH_ACTIVE);
  endtask

  task automatic compare_flag(input string name, input logic e, input logic a);
    if (e !== a) begin
      $error("%s: expected %0b, got %0b", name, e, a);
      fails++;
    end
  endtask

  task automatic check_actions(input umts_pkg::out_item_t e, input umts_pkg::out_item_t a);
    compare_flag("act_prepare_usb", e.act_prepare_usb, a.act_prepare_usb);
    compare_flag("act_enable_timer", e.act_enable_timer, a.act_enable_timer);
    compare_flag("act_disable_timer", e.act_disable_timer, a.act_disable_timer);
    compare_flag("act_start_transfer", e.act_start_transfer, a.act_start_transfer);
    compare_flag("act_request_aux", e.act_request_aux, a.act_request_aux);
    compare_flag("act_mark_status", e.act_mark_status, a.act_mark_status);
    compare_flag("act_init_direct", e.act_init_direct, a.act_init_direct);
    compare_flag("act_request_protocol", e.act_request_protocol, a.act_request_protocol);
    compare_flag("act_activate_updater", e.act_activate_updater, a.act_activate_updater);
    compare_flag("act_service_updater", e.act_service_updater, a.act_service_updater);
    compare_flag("act_restore_normal", e.act_restore_normal, a.act_restore_normal);
    compare_flag("is_active", e.is_active, a.is_active);
  endtask

  // Queue one item and follow it in the planning copy.
  task automatic queue_item(input logic [1:0] cmd, input logic [2:0] mode,
                            input logic [31:0] now, input logic aux, input logic usb,
                            input logic wheel, input logic [1:0] xs, input logic ack);
    umts_pkg::in_item_t  it;
    umts_pkg::out_item_t unused;
    it.command = cmd;
    it.requested_mode = mode;
    it.now_ms = now;
    it.aux_handshake_done = aux;
    it.usb_ready = usb;
    it.wheel_status_seen = wheel;
    it.xfer_status = xs;
    it.protocol_acked = ack;
    advance_sequencer(plan_st, cfg_regs, it, unused);
    plan_now = now;
    pending_items.push_back(it);
  endtask

  // Random item shaped by the planned phase. Outside the final walk, only items that keep the
  // sequencer on the recovery loop (idle, waiting to start, waiting for the transfer) are kept,
  // since every other path leaves that loop for good.
  task automatic queue_random_item(input bit journey);
    seq_track_t          trial;
    umts_pkg::out_item_t unused;
    umts_pkg::in_item_t  c;
    logic [31:0]         target;
    int                  r;
    int                  tries;
    bit                  ok;
    ok = 1'b0;
    trial = plan_st;
    for (tries = 0; tries < 20 && !ok; tries++) begin
      c.requested_mode     = 3'($urandom_range(0, 7));
      c.aux_handshake_done = 1'($urandom_range(0, 1));
      c.usb_ready          = 1'($urandom_range(0, 1));
      c.wheel_status_seen  = 1'($urandom_range(0, 1));
      c.xfer_status        = 2'($urandom_range(0, 3));
      c.protocol_acked     = 1'($urandom_range(0, 1));
      // Time mostly creeps forward, sometimes lands on a deadline boundary, rarely jumps anywhere.
      target = (plan_st.ph == umts_pkg::PH_WAIT_START) ? plan_st.start_dl : plan_st.settle_dl;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        c.now_ms = $urandom;
      end else if (r < 30) begin
        case ($urandom_range(0, 4))
          0: c.now_ms = target;
          1: c.now_ms = target + 32'd1;
          2: c.now_ms = target - 32'd1;
          3: c.now_ms = target + 32'h8000_0000;
          default: c.now_ms = target + 32'h7FFF_FFFF;
        endcase
      end else begin
        c.now_ms = plan_now + $urandom_range(0, 3000);
      end
      r = $urandom_range(0, 99);
      if (plan_st.ph == umts_pkg::PH_IDLE && journey) begin
        if (r < 80) begin
          c.command = umts_pkg::CMD_START;
          c.requested_mode = journey_mode;
        end else begin
          c.command = umts_pkg::CMD_STEP;
        end
      end else if (plan_st.ph == umts_pkg::PH_IDLE) begin
        if (r < 55) begin
          c.command = umts_pkg::CMD_RECOVER;
        end else if (r < 70) begin
          c.command = umts_pkg::CMD_START;
          case ($urandom_range(0, 2))
            0: c.requested_mode = umts_pkg::MODE_NORMAL;
            1: c.requested_mode = MODE_SPARE6;
            default: c.requested_mode = MODE_SPARE7;
          endcase
        end else if (r < 92) begin
          c.command = umts_pkg::CMD_STEP;
        end else begin
          c.command = CMD_RESERVED;
        end
      end else begin
        if (r < 82) c.command = umts_pkg::CMD_STEP;
        else if (r < 90) c.command = umts_pkg::CMD_START;
        else if (r < 95) c.command = umts_pkg::CMD_RECOVER;
        else c.command = CMD_RESERVED;
      end
      trial = plan_st;
      advance_sequencer(trial, cfg_regs, c, unused);
      ok = journey || trial.ph == umts_pkg::PH_IDLE || trial.ph == umts_pkg::PH_WAIT_START ||
           trial.ph == umts_pkg::PH_WAIT_XFER;
    end
    // A reserved command never moves the sequencer, so it is always safe.
    if (!ok) begin
      c.command = CMD_RESERVED;
      trial = plan_st;
      advance_sequencer(trial, cfg_regs, c, unused);
    end
    plan_st = trial;
    plan_now = c.now_ms;
    pending_items.push_back(c);
  endtask

  // One register write; both mirrors share the register copy.
  task automatic write_register(input logic [umts_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      umts_pkg::CFG_START_DELAY:       cfg_regs.start_wait_ms = val;
      umts_pkg::CFG_STANDARD_SETTLE:   cfg_regs.standard_settle_ms = val;
      umts_pkg::CFG_USB_SETTLE:        cfg_regs.usb_settle_ms = val;
      umts_pkg::CFG_PROTOCOL_WAIT:     cfg_regs.protocol_wait_ms = val;
      umts_pkg::CFG_PROTOCOL_START_DL: cfg_regs.proto_start_wait_ms = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] sd, input logic [15:0] st, input logic [15:0] us,
                           input logic [15:0] pw, input logic [15:0] ps);
    write_register(umts_pkg::CFG_START_DELAY, sd);
    write_register(umts_pkg::CFG_STANDARD_SETTLE, st);
    write_register(umts_pkg::CFG_USB_SETTLE, us);
    write_register(umts_pkg::CFG_PROTOCOL_WAIT, pw);
    write_register(umts_pkg::CFG_PROTOCOL_START_DL, ps);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit journey);
    int i;
    for (i = 0; i < count; i++) queue_random_item(journey);
  endtask

  // Wait until every queued item has gone in and every expected result has come out.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_actions.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sender: items change at the falling edge and hold while stalled.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        next_item = pending_items.pop_front();
        in_item  <= next_item;
        in_valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          gap_left = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          send_calm = $urandom_range(20, 60);
          gap_left = 0;
        end else begin
          gap_left = idle_length();
        end
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off once results are flowing.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen >= 500) begin
      hold_done = 1'b1;
      hold_left = 79;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_calm > 0) begin
      out_stall <= 1'b0;
      stall_calm--;
    end else if ($urandom_range(0, 39) == 0) begin
      stall_calm = $urandom_range(20, 60);
      out_stall <= 1'b0;
    end else begin
      stall_left = idle_length();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: check the oldest expectation first, then predict for an item taken at this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_actions.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          fails++;
        end else begin
          oldest = expected_actions.pop_front();
          check_actions(oldest, out_item);
        end
      end
      if (in_valid && !in_stall) begin
        advance_sequencer(track_st, cfg_regs, in_item, predicted);
        expected_actions.push_back(predicted);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    track_st = '0;
    plan_st  = '0;
    plan_now = '0;
    journey_mode = umts_pkg::MODE_AUX;
    cfg_regs = {umts_pkg::RST_START_DELAY, umts_pkg::RST_STANDARD_SETTLE,
                umts_pkg::RST_USB_SETTLE, umts_pkg::RST_PROTOCOL_WAIT,
                umts_pkg::RST_PROTOCOL_START_DL};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle steps, reserved command, unsupported modes, wrapped deadlines and the
    // exact boundaries of the deadline test, busy requests, reserved transfer status.
    queue_item(umts_pkg::CMD_STEP, MODE_SPARE7, 32'h0, 1'b1, 1'b1, 1'b1,
               umts_pkg::XS_COMPLETE, 1'b1);
    queue_item(CMD_RESERVED, MODE_SPARE7, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, XS_RESERVED, 1'b1);
    queue_item(umts_pkg::CMD_START, umts_pkg::MODE_NORMAL, 32'h10, 1'b0, 1'b0, 1'b0,
               XS_PENDING, 1'b0);
    queue_item(umts_pkg::CMD_START, MODE_SPARE6, 32'h11, 1'b0, 1'b0, 1'b0, XS_PENDING, 1'b0);
    queue_item(umts_pkg::CMD_START, MODE_SPARE7, 32'h12, 1'b0, 1'b0, 1'b0, XS_PENDING, 1'b0);
    queue_item(umts_pkg::CMD_RECOVER, umts_pkg::MODE_NORMAL, 32'hFFFF_FFF8, 1'b0, 1'b0, 1'b0,
               XS_PENDING, 1'b0);
    queue_item(umts_pkg::CMD_START, umts_pkg::MODE_AUX, 32'hFFFF_FFF9, 1'b1, 1'b1, 1'b1,
               XS_PENDING, 1'b1);
    queue_item(umts_pkg::CMD_RECOVER, umts_pkg::MODE_PROTOCOL, 32'hFFFF_FFFA, 1'b0, 1'b0,
               1'b0, XS_PENDING, 1'b0);
    queue_item(umts_pkg::CMD_STEP, umts_pkg::MODE_NORMAL, 32'h2, 1'b1, 1'b1, 1'b1,
               umts_pkg::XS_COMPLETE, 1'b1);
    queue_item(umts_pkg::CMD_STEP, umts_pkg::MODE_NORMAL, 32'h8000_0002, 1'b0, 1'b0, 1'b0,
               umts_pkg::XS_FAILED, 1'b0);
    queue_item(umts_pkg::CMD_STEP, umts_pkg::MODE_NORMAL, 32'h3, 1'b0, 1'b0, 1'b0,
               XS_PENDING, 1'b0);
    queue_item(umts_pkg::CMD_STEP, umts_pkg::MODE_USB, 32'h4, 1'b1, 1'b1, 1'b1,
               XS_RESERVED, 1'b1);
    queue_item(umts_pkg::CMD_STEP, umts_pkg::MODE_NORMAL, 32'h5, 1'b0, 1'b0, 1'b0,
               XS_PENDING, 1'b0);
    queue_item(umts_pkg::CMD_STEP, umts_pkg::MODE_NORMAL, 32'h6, 1'b0, 1'b0, 1'b0,
               umts_pkg::XS_FAILED, 1'b0);
    queue_item(CMD_RESERVED, umts_pkg::MODE_NORMAL, 32'h7, 1'b0, 1'b0, 1'b0,
               XS_PENDING, 1'b0);
    queue_item(umts_pkg::CMD_RECOVER, umts_pkg::MODE_STATUS, 32'd100, 1'b0, 1'b0, 1'b0,
               XS_PENDING, 1'b0);
    queue_item(umts_pkg::CMD_STEP, umts_pkg::MODE_NORMAL, 32'd110 + 32'h7FFF_FFFF, 1'b0,
               1'b0, 1'b0, XS_PENDING, 1'b0);
    queue_item(umts_pkg::CMD_STEP, umts_pkg::MODE_NORMAL, 32'h8000_0100, 1'b0, 1'b0, 1'b0,
               umts_pkg::XS_FAILED, 1'b0);
    run_random(340, 1'b0);
    wait_drained();

    // Recovery loops under several register settings, extremes first
    configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(340, 1'b0);
    wait_drained();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(340, 1'b0);
    wait_drained();
    configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(340, 1'b0);
    wait_drained();
    configure(16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
              16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
              16'($urandom_range(0, 50)));
    run_random(340, 1'b0);
    wait_drained();

    // One walk through a supported mode into updater mode, which the sequencer never leaves.
    configure(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(0, 2000)));
    journey_mode = 3'($urandom_range(1, 5));
    run_random(200, 1'b1);
    wait_drained();
    repeat (8) @(posedge clk);

    if (fails == 0) begin
      $display("usb_mode_transition_sequencer regression: pass");
    end else begin
      $display("usb_mode_transition_sequencer regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("usb_mode_transition_sequencer regression: fail");
    $finish;
  end

endmodule
